FILE: sv/fuqd_pkg.sv
// shared types, character codes and helpers for the form-urlencoded query decoder
// used by the front, queue, back and top-level modules; no dependencies
`default_nettype none

package fuqd_pkg;

  // raw character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] HEX_LETTERS = 8'd6;
  localparam logic [7:0] DEC_DIGITS  = 8'd10;

  // results per input item and queue sizing
  localparam int unsigned MAX_RES     = 4;
  localparam int unsigned RES_IDX_W   = 2;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  typedef enum logic [1:0] {
    KIND_NAME  = 2'd0,
    KIND_VALUE = 2'd1,
    KIND_END   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ESC_NONE  = 2'd0,
    ESC_PCT   = 2'd1,
    ESC_DIGIT = 2'd2
  } esc_e;

  typedef struct packed {
    logic [7:0] data;
    kind_e      kind;
    logic       has_value;
    logic       query_end;
  } entry_t;

  // results of one input item; last_idx is the index of the final entry
  typedef struct packed {
    logic [RES_IDX_W-1:0]  last_idx;
    entry_t [MAX_RES-1:0]  ent;
  } pkt_t;

  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

  function automatic entry_t mk_entry(input logic [7:0] data, input kind_e kind,
                                      input logic has_value, input logic query_end);
    entry_t e;
    e.data      = data;
    e.kind      = kind;
    e.has_value = has_value;
    e.query_end = query_end;
    return e;
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    logic r;
    r = (c >= CH_ZERO && c < CH_ZERO + DEC_DIGITS) ||
        (c >= CH_UA && c < CH_UA + HEX_LETTERS) ||
        (c >= CH_LA && c < CH_LA + HEX_LETTERS);
    return r;
  endfunction

  // valid for hex characters only: letters have bit 6 set and low nibble 1..6
  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [3:0] r;
    r = c[6] ? (c[3:0] + 4'd9) : c[3:0];
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: sv/fuqd_front.sv
// front end: accepts raw query bytes, tracks escape and name/value state
// and builds the packet of results for each byte; uses fuqd_pkg
`default_nettype none

module fuqd_front
  import fuqd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       in_carries_i,
  input  wire logic       in_last_i,
  output logic            in_ready_o,
  input  wire qstat_t     qstat_i,
  output logic            push_o,
  output pkt_t            pkt_o
);

  esc_e       esc_q, esc_d;
  logic [7:0] held_q, held_d;
  logic       seen_q, seen_d;
  logic       started_q, started_d;

  logic                 accept;
  entry_t [MAX_RES-1:0] ent_v;
  logic [RES_IDX_W:0]   n_v;

  assign in_ready_o = !qstat_i.full;
  assign accept     = in_valid_i && !qstat_i.full;

  always_comb begin
    logic   zero_end;
    kind_e  dkind;
    ent_v     = '0;
    n_v       = '0;
    dkind     = KIND_NAME;
    esc_d     = esc_q;
    held_d    = held_q;
    seen_d    = seen_q;
    started_d = started_q;
    zero_end  = in_carries_i && (in_byte_i == CH_NUL);

    if (in_carries_i && !zero_end) begin
      started_d = 1'b1;
      dkind = seen_d ? KIND_VALUE : KIND_NAME;
      if (esc_d == ESC_PCT && is_hex(in_byte_i)) begin
        held_d = in_byte_i;
        esc_d  = ESC_DIGIT;
      end else if (esc_d == ESC_DIGIT && is_hex(in_byte_i)) begin
        ent_v[n_v[RES_IDX_W-1:0]] =
          mk_entry({hex_nibble(held_d), hex_nibble(in_byte_i)}, dkind, 1'b0, 1'b0);
        n_v    = n_v + 1'b1;
        esc_d  = ESC_NONE;
        held_d = '0;
      end else begin
        // broken escape goes out literally
        case (esc_d)
          ESC_PCT: begin
            ent_v[n_v[RES_IDX_W-1:0]] = mk_entry(CH_PCT, dkind, 1'b0, 1'b0);
            n_v = n_v + 1'b1;
          end
          ESC_DIGIT: begin
            ent_v[n_v[RES_IDX_W-1:0]] = mk_entry(CH_PCT, dkind, 1'b0, 1'b0);
            n_v = n_v + 1'b1;
            ent_v[n_v[RES_IDX_W-1:0]] = mk_entry(held_d, dkind, 1'b0, 1'b0);
            n_v = n_v + 1'b1;
          end
          default: ;
        endcase
        esc_d  = ESC_NONE;
        held_d = '0;
        if (in_byte_i == CH_PCT) begin
          esc_d = ESC_PCT;
        end else if (in_byte_i == CH_PLUS) begin
          ent_v[n_v[RES_IDX_W-1:0]] = mk_entry(CH_SPACE, dkind, 1'b0, 1'b0);
          n_v = n_v + 1'b1;
        end else if (in_byte_i == CH_AMP) begin
          ent_v[n_v[RES_IDX_W-1:0]] = mk_entry(CH_NUL, KIND_END, seen_d, 1'b0);
          n_v    = n_v + 1'b1;
          seen_d = 1'b0;
        end else if (in_byte_i == CH_EQ && !seen_d) begin
          seen_d = 1'b1;
        end else begin
          ent_v[n_v[RES_IDX_W-1:0]] = mk_entry(in_byte_i, dkind, 1'b0, 1'b0);
          n_v = n_v + 1'b1;
        end
      end
    end

    if (zero_end || in_last_i) begin
      if (started_d) begin
        dkind = seen_d ? KIND_VALUE : KIND_NAME;
        case (esc_d)
          ESC_PCT: begin
            ent_v[n_v[RES_IDX_W-1:0]] = mk_entry(CH_PCT, dkind, 1'b0, 1'b0);
            n_v = n_v + 1'b1;
          end
          ESC_DIGIT: begin
            ent_v[n_v[RES_IDX_W-1:0]] = mk_entry(CH_PCT, dkind, 1'b0, 1'b0);
            n_v = n_v + 1'b1;
            ent_v[n_v[RES_IDX_W-1:0]] = mk_entry(held_d, dkind, 1'b0, 1'b0);
            n_v = n_v + 1'b1;
          end
          default: ;
        endcase
        ent_v[n_v[RES_IDX_W-1:0]] = mk_entry(CH_NUL, KIND_END, seen_d, 1'b1);
        n_v = n_v + 1'b1;
      end
      esc_d     = ESC_NONE;
      held_d    = '0;
      seen_d    = 1'b0;
      started_d = 1'b0;
    end
  end

  assign push_o       = accept && (n_v != '0);
  assign pkt_o.ent    = ent_v;
  assign pkt_o.last_idx = RES_IDX_W'(n_v - 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q     <= ESC_NONE;
      held_q    <= '0;
      seen_q    <= 1'b0;
      started_q <= 1'b0;
    end else if (accept) begin
      esc_q     <= esc_d;
      held_q    <= held_d;
      seen_q    <= seen_d;
      started_q <= started_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/fuqd_queue.sv
// short packet queue between the front end and the output sequencer
// uses pkt_t and qstat_t from fuqd_pkg
`default_nettype none

module fuqd_queue
  import fuqd_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire pkt_t  pkt_i,
  input  wire logic  pop_i,
  output pkt_t       head_o,
  output qstat_t     qstat_o,
  output logic [QCNT_W-1:0] count_o
);

  pkt_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign qstat_o.empty = (cnt_q == '0);
  assign qstat_o.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign do_push = push_i && !qstat_o.full;
  assign do_pop  = pop_i && !qstat_o.empty;
  assign head_o  = mem_q[rd_q];
  assign count_o = cnt_q;

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop  ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= pkt_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/fuqd_back.sv
// back end: walks the head packet one result per transfer and marks its last one
// uses pkt_t, qstat_t and entry_t from fuqd_pkg
`default_nettype none

module fuqd_back
  import fuqd_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire pkt_t   head_i,
  input  wire qstat_t qstat_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  wire logic   out_ready_i,
  output entry_t      out_ent_o,
  output logic        out_last_o
);

  logic [RES_IDX_W-1:0] idx_q, idx_d;
  logic                 xfer;

  assign out_valid_o = !qstat_i.empty;
  assign out_ent_o   = head_i.ent[idx_q];
  assign out_last_o  = (idx_q == head_i.last_idx);
  assign xfer        = out_valid_o && out_ready_i;
  assign pop_o       = xfer && out_last_o;

  always_comb begin
    idx_d = idx_q;
    if (xfer) begin
      idx_d = out_last_o ? '0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/form_urlencoded_query_decoder_unit.sv
// form-urlencoded query decoder: front end, packet queue, output sequencer
// results of a byte are registered in the packet queue when it is accepted and leave from the queue head
// throughput: one input byte per cycle while the four-packet queue has room;
// one result per cycle out while m_axis_tready is high, so a byte causing k results takes k output transfers
// reset: asynchronous, clears escape/name state, queue pointers and sequencer index
`default_nettype none

module form_urlencoded_query_decoder_unit
  import fuqd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  wire logic        s_axis_tuser,   // [0] carries_byte
  input  wire logic        s_axis_tlast,   // is_last
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [7:0] out_byte, [8] has_value, [9] query_end
  output logic [1:0]       m_axis_tuser,   // [1:0] kind
  output logic             m_axis_tlast    // run_last
);

  qstat_t            qstat;
  pkt_t              push_pkt, head_pkt;
  logic              push, pop;
  entry_t            out_ent;
  logic [QCNT_W-1:0] q_count;

  fuqd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_byte_i    (s_axis_tdata),
    .in_carries_i (s_axis_tuser),
    .in_last_i    (s_axis_tlast),
    .in_ready_o   (s_axis_tready),
    .qstat_i      (qstat),
    .push_o       (push),
    .pkt_o        (push_pkt)
  );

  fuqd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pkt_i   (push_pkt),
    .pop_i   (pop),
    .head_o  (head_pkt),
    .qstat_o (qstat),
    .count_o (q_count)
  );

  fuqd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_pkt),
    .qstat_i     (qstat),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_ent_o   (out_ent),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {6'b0, out_ent.query_end, out_ent.has_value, out_ent.data};
  assign m_axis_tuser = out_ent.kind;

  // the final parameter end is always the last result of its byte
  a_qend_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[9]) |-> (m_axis_tlast && m_axis_tuser == KIND_END))
    else $error("query end not on last result");

  // data bytes never carry parameter-end flags
  a_data_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != KIND_END) |-> (m_axis_tdata[9:8] == 2'b00))
    else $error("flags set on data result");

  // parameter ends carry a zero byte
  a_end_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == KIND_END) |-> (m_axis_tdata[7:0] == 8'h00))
    else $error("nonzero byte on parameter end");

  // queue never overfills and ready tracks its room
  a_queue_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_count <= QCNT_W'(QUEUE_DEPTH)) && (s_axis_tready == (q_count != QCNT_W'(QUEUE_DEPTH))))
    else $error("queue occupancy out of range");

endmodule

`default_nettype wire
